// File: hdl/uart_command_line_assembler_assert.svh
// assertion macros for the command line assembler
`ifndef UART_COMMAND_LINE_ASSEMBLER_ASSERT_SVH
`define UART_COMMAND_LINE_ASSEMBLER_ASSERT_SVH

// checked only outside reset
`define UCLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also while reset is applied
`define UCLA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ucla_pkg.sv
// shared constants, types and helpers for the command line assembler
package ucla_pkg;

    localparam int RX_LEN = 32;
    localparam int PTR_W  = $clog2(RX_LEN);

    localparam logic [7:0] NL_CHAR = 8'h0A;
    localparam logic [7:0] CR_CHAR = 8'h0D;

    typedef logic [PTR_W-1:0] ptr_t;

    // one write port and one read port of the line store
    typedef struct packed {
        logic       we;
        ptr_t       waddr;
        logic [7:0] wdata;
        logic       re;
        ptr_t       raddr;
    } ram_req_t;

    // status seen by the top level
    typedef struct packed {
        logic busy;
        logic idle;
    } ctrl_stat_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(RX_LEN - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // ring position n entries back from p, n below RX_LEN
    function automatic ptr_t ptr_back(input ptr_t p, input ptr_t n);
        logic [PTR_W:0] r;
        if (p >= n)
        begin
            r = {1'b0, p} - {1'b0, n};
        end
        else
        begin
            r = {1'b0, p} + (PTR_W+1)'(RX_LEN) - {1'b0, n};
        end
        return r[PTR_W-1:0];
    endfunction

endpackage

// File: hdl/ucla_line_ram.sv
// ring line store, one write and one registered read port
module ucla_line_ram
(
    input  logic             clk,
    input  ucla_pkg::ram_req_t req,
    output logic [7:0]       rdata
);

    logic [7:0] mem [ucla_pkg::RX_LEN];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        // read data holds until the next read
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ucla_ctrl.sv
// sequencer: stores bytes, replays a line on newline, output register
module ucla_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser,
    output ucla_pkg::ram_req_t     ram_req,
    input  logic [7:0]             ram_rdata,
    output ucla_pkg::ctrl_stat_t   stat
);

    typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_EMPTY} state_t;

    state_t          state_reg, state_next;
    ucla_pkg::ptr_t  pos_reg, pos_next;
    ucla_pkg::ptr_t  cnt_reg, cnt_next;
    ucla_pkg::ptr_t  rd_idx_reg, rd_idx_next;
    ucla_pkg::ptr_t  remain_reg, remain_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    logic            out_empty_reg, out_empty_next;

    logic            out_free;
    logic [7:0]      char_in;
    ucla_pkg::ptr_t  start_pos;

    assign char_in   = (s_tdata == ucla_pkg::CR_CHAR) ? ucla_pkg::NL_CHAR : s_tdata;
    assign start_pos = ucla_pkg::ptr_back(pos_reg, cnt_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        ram_req        = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // error bytes are dropped without any effect
                if (s_tvalid && !s_tuser)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = char_in;
                    pos_next      = ucla_pkg::ptr_inc(pos_reg);
                    if (char_in == ucla_pkg::NL_CHAR)
                    begin
                        cnt_next = '0;
                        if (cnt_reg == '0)
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = '0;
                                out_last_next  = 1'b1;
                                out_empty_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_EMPTY;
                            end
                        end
                        else
                        begin
                            // first read of the line goes out with the newline write
                            ram_req.re    = 1'b1;
                            ram_req.raddr = start_pos;
                            rd_idx_next   = ucla_pkg::ptr_inc(start_pos);
                            remain_next   = cnt_reg;
                            state_next    = ST_EMIT;
                        end
                    end
                    else if (cnt_reg != ucla_pkg::PTR_W'(ucla_pkg::RX_LEN - 1))
                    begin
                        cnt_next = cnt_reg + ucla_pkg::PTR_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_empty_next = 1'b0;
                    out_last_next  = (remain_reg == ucla_pkg::PTR_W'(1));
                    if (remain_reg == ucla_pkg::PTR_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = rd_idx_reg;
                        rd_idx_next   = ucla_pkg::ptr_inc(rd_idx_reg);
                        remain_next   = remain_reg - ucla_pkg::PTR_W'(1);
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= ucla_pkg::PTR_W'(1 % ucla_pkg::RX_LEN);
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_empty_reg;
    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.idle = (state_reg == ST_IDLE);

endmodule

// File: hdl/uart_command_line_assembler.sv
// top level: collects uart bytes into lines and replays each line on newline
// output: a stored byte gives no transaction; a newline issues the first line store read, whose
//   registered data enters the output register once it is free (an empty line loads its marker directly)
// throughput: one input per cycle while no line replays and no empty line waits for the output;
//   a line holds the input while it replays, one line store read per output byte
// reset: asynchronous, active low; clears the sequencer and output valid, the store keeps data
`include "uart_command_line_assembler_assert.svh"

module uart_command_line_assembler
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] rx_error
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] line_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] line_empty
);

    ucla_pkg::ram_req_t   ram_req;
    logic [7:0]           ram_rdata;
    ucla_pkg::ctrl_stat_t stat;

    ucla_line_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    ucla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .stat      (stat)
    );

    // no input transaction during a replay
    `UCLA_ASSERT(a_busy_blocks_input, clk, rst_n, stat.busy |-> !s_tready, "input taken during replay")
    // an empty line is a single last transaction carrying zero
    `UCLA_ASSERT(a_empty_is_last, clk, rst_n, (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'h00)), "bad empty line")
    // no store write while reading out a line
    `UCLA_ASSERT(a_no_write_in_replay, clk, rst_n, ram_req.we |-> stat.idle, "store written during replay")
    // reset leaves no pending output
    `UCLA_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !m_tvalid, "output valid after reset")

endmodule

// File: tb/testbench.sv
// self-checking testbench for the uart command line assembler
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } line_char_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // own copy of the line ring and its counters
    logic [7:0]     line_ring [ucla_pkg::RX_LEN];
    ucla_pkg::ptr_t ring_wr;
    logic [5:0]     chars_open;
    line_char_t     line_chars_due [$];

    int mismatch_count = 0;
    int items_sent = 0;
    bit idle_on = 1'b1;
    int hold_seq = 0;
    int hold_len = 0;

    uart_command_line_assembler dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // store one received byte and queue the line characters it releases
    function automatic void assemble_line(input logic [7:0] rx_char, input logic rx_bad);
        logic [7:0] ch;
        int         n;
        line_char_t item;
        ch = rx_char;
        if (!rx_bad)
        begin
            if (ch == ucla_pkg::CR_CHAR)
            begin
                ch = ucla_pkg::NL_CHAR;
            end
            line_ring[ring_wr] = ch;
            if (ch == ucla_pkg::NL_CHAR)
            begin
                n = chars_open;
                if (n == 0)
                begin
                    item.data  = 8'h00;
                    item.last  = 1'b1;
                    item.empty = 1'b1;
                    line_chars_due.push_back(item);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        item.data  = line_ring[ucla_pkg::ptr_t'((int'(ring_wr)
                                     + ucla_pkg::RX_LEN - n + i) % ucla_pkg::RX_LEN)];
                        item.last  = (i == n - 1);
                        item.empty = 1'b0;
                        line_chars_due.push_back(item);
                    end
                end
                chars_open = '0;
            end
            else if (chars_open < ucla_pkg::RX_LEN - 1)
            begin
                chars_open = chars_open + 6'd1;
            end
            ring_wr = ucla_pkg::ptr_t'((int'(ring_wr) + 1) % ucla_pkg::RX_LEN);
        end
    endfunction

    task automatic send_rx(input logic [7:0] rx_char, input logic rx_bad);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx_char;
        s_tuser  <= rx_bad;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        assemble_line(rx_char, rx_bad);
        if (!rx_bad)
        begin
            items_sent++;
        end
    endtask

    task automatic send_line(input string body, input logic [7:0] term);
        for (int i = 0; i < body.len(); i++)
        begin
            send_rx(body[i], 1'b0);
        end
        send_rx(term, 1'b0);
    endtask

    task automatic send_random_line(input int max_len);
        int         len;
        logic [7:0] ch;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++)
        begin
            // noise with the error flag, terminators included
            if ($urandom_range(0, 9) == 0)
            begin
                ch = ($urandom_range(0, 2) == 0) ? ucla_pkg::NL_CHAR : 8'($urandom);
                send_rx(ch, 1'b1);
            end
            ch = 8'($urandom);
            if (ch == ucla_pkg::NL_CHAR || ch == ucla_pkg::CR_CHAR)
            begin
                ch = ch ^ 8'h80;
            end
            send_rx(ch, 1'b0);
        end
        send_rx($urandom_range(0, 1) ? ucla_pkg::NL_CHAR : ucla_pkg::CR_CHAR, 1'b0);
    endtask

    task automatic test_empty_lines();
        send_rx(ucla_pkg::NL_CHAR, 1'b0);
        send_rx(ucla_pkg::CR_CHAR, 1'b0);
        send_rx(ucla_pkg::NL_CHAR, 1'b0);
    endtask

    task automatic test_extreme_bytes();
        send_rx(8'h00, 1'b0);
        send_rx(8'hFF, 1'b0);
        send_rx(8'h0B, 1'b0);
        send_rx(8'h0C, 1'b0);
        send_rx(ucla_pkg::CR_CHAR, 1'b0);
        send_line("A", ucla_pkg::NL_CHAR);
        send_line("cmd", ucla_pkg::CR_CHAR);
    endtask

    task automatic test_error_bytes();
        send_rx(8'h55, 1'b0);
        send_rx(ucla_pkg::NL_CHAR, 1'b1);
        send_rx(8'hAA, 1'b1);
        send_rx(ucla_pkg::CR_CHAR, 1'b1);
        send_rx(8'h33, 1'b0);
        send_rx(ucla_pkg::NL_CHAR, 1'b0);
        send_rx(8'hFF, 1'b1);
        send_rx(ucla_pkg::CR_CHAR, 1'b0);
    endtask

    task automatic test_overlong_lines();
        // exactly the ring limit, then five and ten past it, beyond a full wrap
        for (int n = ucla_pkg::RX_LEN - 1; n <= ucla_pkg::RX_LEN + 9; n += 5)
        begin
            for (int i = 0; i < n; i++)
            begin
                send_rx(8'(8'h21 + i), 1'b0);
            end
            send_rx(ucla_pkg::NL_CHAR, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        hold_len = 150;
        hold_seq++;
        for (int k = 0; k < 4; k++)
        begin
            send_random_line(12);
        end
    endtask

    task automatic test_random_traffic();
        int target;
        target = items_sent + 100;
        while (items_sent < target)
        begin
            send_random_line(($urandom_range(0, 9) == 0) ? 45 : 8);
        end
    endtask

    task automatic test_no_idle();
        int target;
        idle_on = 1'b0;
        target = items_sent + 60;
        while (items_sent < target)
        begin
            send_random_line(10);
        end
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int seen_hold;
        seen_hold = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_seq != seen_hold)
            begin
                seen_hold = hold_seq;
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare every output transaction with the oldest queued line character
    always @(posedge clk)
    begin
        line_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_chars_due.size() == 0)
            begin
                $display("%0t: unexpected transaction data=%h last=%b empty=%b",
                         $realtime, m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = line_chars_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.empty)
                begin
                    $display("%0t: expected data=%h last=%b empty=%b",
                             $realtime, want.data, want.last, want.empty,
                             " actual data=%h last=%b empty=%b",
                             m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < ucla_pkg::RX_LEN; i++)
        begin
            line_ring[i] = 8'h00;
        end
        line_ring[0] = ucla_pkg::NL_CHAR;
        ring_wr      = ucla_pkg::ptr_t'(1);
        chars_open   = '0;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lines();
        test_extreme_bytes();
        test_error_bytes();
        test_overlong_lines();
        test_backpressure();
        test_random_traffic();
        test_no_idle();
        s_tvalid <= 1'b0;

        while (line_chars_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && line_chars_due.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ucla_pkg.sv
hdl/ucla_line_ram.sv
hdl/ucla_ctrl.sv
hdl/uart_command_line_assembler.sv
tb/testbench.sv
